@@ rtl/core/fm_discriminator_deemphasis_defines.svh @@
// ----------------------------------------------------------------------------
// FM discriminator assertion macros
// Shared concurrent assertion wrappers, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef FM_DISCRIMINATOR_DEEMPHASIS_DEFINES_SVH
`define FM_DISCRIMINATOR_DEEMPHASIS_DEFINES_SVH

`ifndef SYNTHESIS
`define FMDD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("property violated");
`define FMDD_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define FMDD_ASSERT(lbl, prop)
`define FMDD_NEVER(lbl, expr)
`endif

`endif

@@ rtl/core/fmdd_pkg.sv @@
// ----------------------------------------------------------------------------
// FM discriminator package
// Widths, register codes, shared types and helper functions.
// ----------------------------------------------------------------------------
package fmdd_pkg;

    localparam int SAMPLE_WIDTH  = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int ACCUM_WIDTH   = 32;

    localparam int GUARD_BITS  = ACCUM_WIDTH - SAMPLE_WIDTH;
    localparam int DEMOD_SHIFT = 48 - SAMPLE_WIDTH;
    localparam int PROD_W      = 2 * SAMPLE_WIDTH;
    localparam int DOT_W       = 2 * SAMPLE_WIDTH + 1;
    localparam int VEC_W       = 2 * SAMPLE_WIDTH + 4;
    localparam int ANG_W       = 34;
    localparam int COEF_W      = 16;
    localparam int GPROD_W     = ANG_W + COEF_W + 1;
    localparam int FPROD_W     = ACCUM_WIDTH + 1 + COEF_W + 1;
    localparam int ITER_W      = $clog2(CORDIC_STAGES);
    localparam int ATAN_IDX_W  = 5;
    localparam int DECIM_W     = 5;
    localparam int DCNT_W      = 4;
    localparam int CFG_INDEX_W = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = ANG_W'(64'sd1073741824);

    localparam logic [CFG_INDEX_W-1:0] CFG_PRE_DECIMATION  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POST_DECIMATION = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEMOD_GAIN      = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEEMPH_ALPHA    = 8'd3;

    localparam logic [DECIM_W-1:0] PRE_DECIMATION_RST  = 5'd8;
    localparam logic [DECIM_W-1:0] POST_DECIMATION_RST = 5'd5;
    localparam logic [COEF_W-1:0]  DEMOD_GAIN_RST      = 16'd26214;
    localparam logic [COEF_W-1:0]  DEEMPH_ALPHA_RST    = 16'd5240;

    typedef struct packed {
        logic [DECIM_W-1:0] pre_decimation;
        logic [DECIM_W-1:0] post_decimation;
        logic [COEF_W-1:0]  demod_gain;
        logic [COEF_W-1:0]  deemph_alpha;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] cur_i;
        logic signed [SAMPLE_WIDTH-1:0] cur_q;
        logic signed [SAMPLE_WIDTH-1:0] prev_i;
        logic signed [SAMPLE_WIDTH-1:0] prev_q;
    } pair_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic [DECIM_W-1:0] eff_factor(input logic [DECIM_W-1:0] r);
        logic [DECIM_W-1:0] f;
        if (r == '0)
            f = DECIM_W'(1);
        else if (r > DECIM_W'(16))
            f = DECIM_W'(16);
        else
            f = r;
        return f;
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [63:0] v
    );
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        logic signed [SAMPLE_WIDTH-1:0] r;
        hi = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
            r = SAMPLE_WIDTH'(hi);
        else if (v < lo)
            r = SAMPLE_WIDTH'(lo);
        else
            r = SAMPLE_WIDTH'(v);
        return r;
    endfunction

    function automatic logic signed [ANG_W-1:0] atan_entry(
        input logic [ATAN_IDX_W-1:0] k
    );
        logic [31:0] a;
        case (k)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = 32'd0;
        endcase
        return signed'(ANG_W'(a));
    endfunction

endpackage

@@ rtl/core/fm_discriminator_deemphasis.sv @@
// ----------------------------------------------------------------------------
// FM polar discriminator with de-emphasis
// Decimates filtered I/Q, demodulates FM by conjugate product and CORDIC
// phase, applies a one-pole de-emphasis filter and decimates the audio.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries I/Q samples; m_axis carries audio samples. Both complete
//   a request when tvalid and tready are high at a rising edge of clk.
//   cfg writes one register per request (index 0..3), taken at once.
//   The front end keeps one of every pre_decimation samples (0 acts as 1,
//   above 16 as 16) and takes one sample per cycle while its four-entry
//   pair queue has room. The back end takes one kept sample at a time:
//   the shared multiplier forms the conjugate product, 16 CORDIC iterations
//   find its phase, then gain, rounding and filter steps follow (the first
//   filtered sample only seeds the filter and skips its multiply and update).
//   An audio sample is written to the output register once that register
//   is free, then holds until taken.
//   While the receiver stalls, the back end waits with one finished sample
//   and the queue fills; s_axis_tready falls when it is full.
//   Reset loads the register defaults, clears the decimation phases, the
//   previous-sample flag, the filter seed flag and the output valid flag.
// ----------------------------------------------------------------------------
module fm_discriminator_deemphasis (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [2*fmdd_pkg::SAMPLE_WIDTH-1:0]   s_axis_tdata,   // q_sample (upper half), i_sample (lower half)
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [fmdd_pkg::SAMPLE_WIDTH-1:0]     m_axis_tdata,   // audio_sample
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fmdd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [fmdd_pkg::COEF_W-1:0]           cfg_data
);

    localparam int SW = fmdd_pkg::SAMPLE_WIDTH;

    fmdd_pkg::cfg_t   cfg_reg;
    fmdd_pkg::qstat_t qstat;
    fmdd_pkg::pair_t  push_data;
    fmdd_pkg::pair_t  pop_data;
    logic             push;
    logic             pop;
    logic signed [SW-1:0] audio;

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = audio;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pre_decimation  <= fmdd_pkg::PRE_DECIMATION_RST;
            cfg_reg.post_decimation <= fmdd_pkg::POST_DECIMATION_RST;
            cfg_reg.demod_gain      <= fmdd_pkg::DEMOD_GAIN_RST;
            cfg_reg.deemph_alpha    <= fmdd_pkg::DEEMPH_ALPHA_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fmdd_pkg::CFG_PRE_DECIMATION:
                    cfg_reg.pre_decimation <= cfg_data[fmdd_pkg::DECIM_W-1:0];
                fmdd_pkg::CFG_POST_DECIMATION:
                    cfg_reg.post_decimation <= cfg_data[fmdd_pkg::DECIM_W-1:0];
                fmdd_pkg::CFG_DEMOD_GAIN:
                    cfg_reg.demod_gain <= cfg_data;
                fmdd_pkg::CFG_DEEMPH_ALPHA:
                    cfg_reg.deemph_alpha <= cfg_data;
                default: ;
            endcase
        end
    end

    fmdd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_i      (signed'(s_axis_tdata[SW-1:0])),
        .in_q      (signed'(s_axis_tdata[2*SW-1:SW])),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    fmdd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .stat      (qstat)
    );

    fmdd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .qstat     (qstat),
        .q_data    (pop_data),
        .q_pop     (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (audio)
    );

endmodule

@@ rtl/core/fmdd_front.sv @@
// ----------------------------------------------------------------------------
// FM discriminator front end
// Accepts I/Q samples, decimates them and pairs each kept sample with the
// previous kept sample for the discriminator.
// ----------------------------------------------------------------------------
module fmdd_front (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  fmdd_pkg::cfg_t                          cfg,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0] in_i,
    input  logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0] in_q,
    input  fmdd_pkg::qstat_t                        qstat,
    output logic                                    push,
    output fmdd_pkg::pair_t                         push_data
);

    logic [fmdd_pkg::DCNT_W-1:0]  pre_cnt_reg;
    logic [fmdd_pkg::DCNT_W-1:0]  pre_cnt_next;
    logic [fmdd_pkg::DECIM_W-1:0] cnt_inc;
    logic                         have_prev_reg;
    logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0] prev_i_reg;
    logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0] prev_q_reg;
    logic                         accept;
    logic                         hit;

    always_comb
    begin
        in_ready = !qstat.full;
        accept   = in_valid && in_ready;
        hit      = (pre_cnt_reg == '0);
        cnt_inc  = {1'b0, pre_cnt_reg} + fmdd_pkg::DECIM_W'(1);
        if (cnt_inc >= fmdd_pkg::eff_factor(cfg.pre_decimation))
            pre_cnt_next = '0;
        else
            pre_cnt_next = cnt_inc[fmdd_pkg::DCNT_W-1:0];
        push             = accept && hit && have_prev_reg;
        push_data.cur_i  = in_i;
        push_data.cur_q  = in_q;
        push_data.prev_i = prev_i_reg;
        push_data.prev_q = prev_q_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_cnt_reg   <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (accept)
        begin
            pre_cnt_reg <= pre_cnt_next;
            if (hit)
                have_prev_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hit)
        begin
            prev_i_reg <= in_i;
            prev_q_reg <= in_q;
        end
    end

endmodule

@@ rtl/core/fmdd_queue.sv @@
// ----------------------------------------------------------------------------
// FM discriminator request queue
// Short FIFO of sample pairs between the front end and the back end.
// ----------------------------------------------------------------------------
`include "fm_discriminator_deemphasis_defines.svh"

module fmdd_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  fmdd_pkg::pair_t  push_data,
    input  logic             pop,
    output fmdd_pkg::pair_t  pop_data,
    output fmdd_pkg::qstat_t stat
);

    fmdd_pkg::pair_t mem [fmdd_pkg::QUEUE_DEPTH];

    logic [fmdd_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [fmdd_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [fmdd_pkg::QPTR_W:0]   count_reg;

    always_comb
    begin
        stat.full  = (count_reg == (fmdd_pkg::QPTR_W + 1)'(fmdd_pkg::QUEUE_DEPTH));
        stat.empty = (count_reg == '0);
        pop_data   = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + fmdd_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + fmdd_pkg::QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + (fmdd_pkg::QPTR_W + 1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (fmdd_pkg::QPTR_W + 1)'(1);
        end
    end

    `FMDD_NEVER(a_push_when_full, push && stat.full)
    `FMDD_NEVER(a_pop_when_empty, pop && stat.empty)
    `FMDD_ASSERT(a_ptr_gap, (wr_ptr_reg - rd_ptr_reg) == count_reg[fmdd_pkg::QPTR_W-1:0])

endmodule

@@ rtl/core/fmdd_back.sv @@
// ----------------------------------------------------------------------------
// FM discriminator back end
// Conjugate product, CORDIC phase, gain, de-emphasis filter, output
// decimation and the output register.
// ----------------------------------------------------------------------------
`include "fm_discriminator_deemphasis_defines.svh"

module fmdd_back (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  fmdd_pkg::cfg_t                          cfg,
    input  fmdd_pkg::qstat_t                        qstat,
    input  fmdd_pkg::pair_t                         q_data,
    output logic                                    q_pop,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [fmdd_pkg::SAMPLE_WIDTH-1:0] out_data
);

    localparam int SW  = fmdd_pkg::SAMPLE_WIDTH;
    localparam int AW  = fmdd_pkg::ACCUM_WIDTH;
    localparam int GB  = fmdd_pkg::GUARD_BITS;
    localparam int DS  = fmdd_pkg::DEMOD_SHIFT;
    localparam logic signed [63:0] DEMOD_BIAS = 64'sd1 <<< (DS - 1);
    localparam logic signed [AW:0] OUT_BIAS   = (AW + 1)'(64'sd1 <<< (GB - 1));
    localparam logic signed [fmdd_pkg::FPROD_W-1:0] STEP_BIAS =
        fmdd_pkg::FPROD_W'(64'sd32768);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_PRE,
        ST_ROT,
        ST_GAIN,
        ST_DEMOD,
        ST_DIFF,
        ST_FMUL,
        ST_UPDATE,
        ST_TICK,
        ST_EMIT
    } state_t;

    state_t                                 state_reg;
    logic [2:0]                             step_reg;
    logic [fmdd_pkg::ITER_W-1:0]            iter_reg;
    fmdd_pkg::pair_t                        cur_reg;
    logic signed [fmdd_pkg::PROD_W-1:0]     prod_reg;
    logic signed [fmdd_pkg::DOT_W-1:0]      re_reg;
    logic signed [fmdd_pkg::DOT_W-1:0]      im_reg;
    logic signed [fmdd_pkg::VEC_W-1:0]      x_reg;
    logic signed [fmdd_pkg::VEC_W-1:0]      y_reg;
    logic signed [fmdd_pkg::ANG_W-1:0]      ang_reg;
    logic                                   zero_reg;
    logic signed [fmdd_pkg::GPROD_W-1:0]    gprod_reg;
    logic signed [SW-1:0]                   d_reg;
    logic signed [AW:0]                     diff_reg;
    logic signed [fmdd_pkg::FPROD_W-1:0]    fprod_reg;
    logic signed [AW-1:0]                   acc_reg;
    logic                                   started_reg;
    logic [fmdd_pkg::DCNT_W-1:0]            post_cnt_reg;
    logic                                   out_valid_reg;
    logic signed [SW-1:0]                   out_data_reg;

    logic signed [SW-1:0]                   mul_a;
    logic signed [SW-1:0]                   mul_b;
    logic signed [fmdd_pkg::PROD_W-1:0]     mul_p;
    logic signed [fmdd_pkg::DOT_W-1:0]      prod_ext;
    logic signed [fmdd_pkg::VEC_W-1:0]      x0;
    logic signed [fmdd_pkg::VEC_W-1:0]      y0;
    logic signed [fmdd_pkg::VEC_W-1:0]      x_shift;
    logic signed [fmdd_pkg::VEC_W-1:0]      y_shift;
    logic signed [fmdd_pkg::ANG_W-1:0]      atan_k;
    logic signed [fmdd_pkg::ANG_W-1:0]      ang_eff;
    logic signed [fmdd_pkg::COEF_W:0]       gain_op;
    logic signed [fmdd_pkg::COEF_W:0]       alpha_op;
    logic signed [fmdd_pkg::GPROD_W-1:0]    gprod_comb;
    logic signed [63:0]                     demod_sum;
    logic signed [SW-1:0]                   d_comb;
    logic signed [AW-1:0]                   d_wide;
    logic signed [AW:0]                     diff_comb;
    logic signed [fmdd_pkg::FPROD_W-1:0]    fprod_comb;
    logic signed [fmdd_pkg::FPROD_W-1:0]    step_val;
    logic signed [AW-1:0]                   acc_new;
    logic signed [AW:0]                     out_sum;
    logic signed [SW-1:0]                   out_val;
    logic [fmdd_pkg::DECIM_W-1:0]           post_inc;
    logic [fmdd_pkg::DCNT_W-1:0]            post_cnt_next;
    logic                                   post_hit;
    logic                                   out_free;

    always_comb
    begin
        q_pop = (state_reg == ST_IDLE) && !qstat.empty;

        mul_a = (step_reg == 3'd0 || step_reg == 3'd3) ? cur_reg.cur_i : cur_reg.cur_q;
        mul_b = (step_reg == 3'd0 || step_reg == 3'd2) ? cur_reg.prev_i : cur_reg.prev_q;
        mul_p = mul_a * mul_b;
        prod_ext = fmdd_pkg::DOT_W'(prod_reg);

        x0 = fmdd_pkg::VEC_W'(re_reg);
        y0 = fmdd_pkg::VEC_W'(im_reg);
        x_shift = x_reg >>> iter_reg;
        y_shift = y_reg >>> iter_reg;
        atan_k  = fmdd_pkg::atan_entry(fmdd_pkg::ATAN_IDX_W'(iter_reg));

        ang_eff    = zero_reg ? '0 : ang_reg;
        gain_op    = signed'({1'b0, cfg.demod_gain});
        gprod_comb = ang_eff * gain_op;
        demod_sum  = 64'(gprod_reg) + DEMOD_BIAS;
        d_comb     = fmdd_pkg::sat_sample(demod_sum >>> DS);

        d_wide     = {d_reg, {GB{1'b0}}};
        diff_comb  = (AW + 1)'(d_wide) - (AW + 1)'(acc_reg);
        alpha_op   = signed'({1'b0, cfg.deemph_alpha});
        fprod_comb = diff_reg * alpha_op;
        step_val   = (fprod_reg + STEP_BIAS) >>> 16;
        acc_new    = acc_reg + AW'(step_val);

        out_sum = (AW + 1)'(acc_reg) + OUT_BIAS;
        out_val = fmdd_pkg::sat_sample(64'(out_sum >>> GB));

        post_hit = (post_cnt_reg == '0);
        post_inc = {1'b0, post_cnt_reg} + fmdd_pkg::DECIM_W'(1);
        if (post_inc >= fmdd_pkg::eff_factor(cfg.post_decimation))
            post_cnt_next = '0;
        else
            post_cnt_next = post_inc[fmdd_pkg::DCNT_W-1:0];

        out_free  = !out_valid_reg || out_ready;
        out_valid = out_valid_reg;
        out_data  = out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            started_reg   <= 1'b0;
            post_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_ready && state_reg != ST_EMIT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (!qstat.empty)
                    begin
                        cur_reg   <= q_data;
                        step_reg  <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    prod_reg <= mul_p;
                    step_reg <= step_reg + 3'd1;
                    case (step_reg)
                        3'd1: re_reg <= prod_ext;
                        3'd2: re_reg <= re_reg + prod_ext;
                        3'd3: im_reg <= prod_ext;
                        3'd4:
                        begin
                            im_reg    <= im_reg - prod_ext;
                            state_reg <= ST_PRE;
                        end
                        default: ;
                    endcase
                end
                ST_PRE:
                begin
                    zero_reg <= (re_reg == '0) && (im_reg == '0);
                    iter_reg <= '0;
                    if (x0 < 0)
                    begin
                        if (y0 >= 0)
                        begin
                            x_reg   <= y0;
                            y_reg   <= -x0;
                            ang_reg <= fmdd_pkg::ANG_HALF_PI;
                        end
                        else
                        begin
                            x_reg   <= -y0;
                            y_reg   <= x0;
                            ang_reg <= -fmdd_pkg::ANG_HALF_PI;
                        end
                    end
                    else
                    begin
                        x_reg   <= x0;
                        y_reg   <= y0;
                        ang_reg <= '0;
                    end
                    state_reg <= ST_ROT;
                end
                ST_ROT:
                begin
                    if (y_reg >= 0)
                    begin
                        x_reg   <= x_reg + y_shift;
                        y_reg   <= y_reg - x_shift;
                        ang_reg <= ang_reg + atan_k;
                    end
                    else
                    begin
                        x_reg   <= x_reg - y_shift;
                        y_reg   <= y_reg + x_shift;
                        ang_reg <= ang_reg - atan_k;
                    end
                    iter_reg <= iter_reg + fmdd_pkg::ITER_W'(1);
                    if (iter_reg == fmdd_pkg::ITER_W'(fmdd_pkg::CORDIC_STAGES - 1))
                        state_reg <= ST_GAIN;
                end
                ST_GAIN:
                begin
                    gprod_reg <= gprod_comb;
                    state_reg <= ST_DEMOD;
                end
                ST_DEMOD:
                begin
                    d_reg     <= d_comb;
                    state_reg <= ST_DIFF;
                end
                ST_DIFF:
                begin
                    if (!started_reg)
                    begin
                        acc_reg     <= d_wide;
                        started_reg <= 1'b1;
                        state_reg   <= ST_TICK;
                    end
                    else
                    begin
                        diff_reg  <= diff_comb;
                        state_reg <= ST_FMUL;
                    end
                end
                ST_FMUL:
                begin
                    fprod_reg <= fprod_comb;
                    state_reg <= ST_UPDATE;
                end
                ST_UPDATE:
                begin
                    acc_reg   <= acc_new;
                    state_reg <= ST_TICK;
                end
                ST_TICK:
                begin
                    post_cnt_reg <= post_cnt_next;
                    state_reg    <= post_hit ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= out_val;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `FMDD_ASSERT(a_emit_source, $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
    `FMDD_ASSERT(a_gain_after_rot, (state_reg == ST_GAIN) |-> $past(state_reg == ST_ROT))
    `FMDD_ASSERT(a_filter_seeded, (state_reg == ST_FMUL) |-> started_reg)

endmodule
